>>> rtl/core/memcomparable_key_group_codec_defines.svh
// Assertion macros used by the group codec back end.
`ifndef MEMCOMPARABLE_KEY_GROUP_CODEC_DEFINES_SVH
`define MEMCOMPARABLE_KEY_GROUP_CODEC_DEFINES_SVH

// Clocked check, disabled while reset is high.
`define MKGC_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// Clocked check that also runs during reset.
`define MKGC_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> rtl/core/mkgc_pkg.sv
// Shared types and constants of the memcomparable key group codec.
package mkgc_pkg;

  // Width of count fields in a job; holds up to the largest group size plus spare.
  localparam int CNT_W = 6;

  localparam logic [7:0] MARKER = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_LEN   = 3'd1,
    ST_FF    = 3'd2,
    ST_PAD   = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  // One classified input item, handed from front to back.
  typedef struct packed {
    logic             dec;        // decode job
    logic [7:0]       data_byte;  // encode: plain byte
    logic             has;        // encode: byte present
    logic             mark;       // encode: group completed, emit 0xFF
    logic             key_end;    // last item of the key
    logic [CNT_W-1:0] pad;        // encode: pad zeros before the end marker
    logic [CNT_W-1:0] count;      // decode: real bytes to emit from the group
    status_t          status;     // decode: key status on key_end
  } job_ctrl_t;

endpackage

>>> rtl/core/mkgc_if.sv
// Valid/ready stream interfaces for key bytes in and codec results out.
interface mkgc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       has_byte;
  logic       key_end;

  modport source (output valid, output in_byte, output has_byte, output key_end,
                  input ready);
  modport sink (input valid, input in_byte, input has_byte, input key_end,
                output ready);
endinterface

interface mkgc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       key_done;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output key_done, output status, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input key_done, input status, output ready);
endinterface

>>> rtl/core/memcomparable_key_group_codec.sv
// A result is offered from the registered job queue, not in the cycle its input item transfers.
// Throughput: one result transfer per cycle while key_out.ready is high; an input
// item transfers each cycle while the two-entry job queue has room.
// Sustained encode rate is set by the result sequencer: 9/8 results per byte plus the pad group.
// Reset (rst, synchronous): mode to encode, key state cleared, queue empty; the group
// buffer is not cleared and is always fully written before it is read.
module memcomparable_key_group_codec
  import mkgc_pkg::*;
#(
  parameter int GROUP_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  mkgc_in_if.sink     key_in,
  mkgc_out_if.source  key_out
);

  // Queue word: group bytes above the job control fields.
  localparam int QW = GROUP_SIZE * 8 + $bits(job_ctrl_t);

  logic                       f_valid, f_ready;
  job_ctrl_t                  f_ctrl;
  logic [GROUP_SIZE-1:0][7:0] f_data;
  logic [QW-1:0]              q_din, q_dout;
  logic                       b_valid, b_pop;
  job_ctrl_t                  b_ctrl;
  logic [GROUP_SIZE-1:0][7:0] b_data;

  // Front: mode register, group position, decode buffer and error tracking.
  mkgc_front #(.GROUP_SIZE(GROUP_SIZE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .key_in     (key_in),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_ctrl  (f_ctrl),
    .push_data  (f_data)
  );

  assign q_din = {f_data, f_ctrl};

  // Short queue lets the front keep taking items while results stall.
  mkgc_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_din),
    .pop_valid  (b_valid),
    .pop_ready  (b_pop),
    .pop_data   (q_dout)
  );

  assign {b_data, b_ctrl} = q_dout;

  // Back: walks each job one result per transfer, pops on the last one.
  mkgc_back #(.GROUP_SIZE(GROUP_SIZE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_pop   (b_pop),
    .job_ctrl  (b_ctrl),
    .job_data  (b_data),
    .key_out   (key_out)
  );

endmodule

>>> rtl/core/mkgc_front.sv
// Front end: accepts key items, tracks group state, classifies each item into a job.
module mkgc_front
  import mkgc_pkg::*;
#(
  parameter int GROUP_SIZE = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  mkgc_in_if.sink                       key_in,
  output logic                          push_valid,
  input  logic                          push_ready,
  output job_ctrl_t                     push_ctrl,
  output logic [GROUP_SIZE-1:0][7:0]    push_data
);

  localparam int CW = $clog2(GROUP_SIZE + 1);
  localparam int IW = $clog2(GROUP_SIZE);
  localparam logic [CW-1:0] GS_C = CW'(GROUP_SIZE);
  localparam logic [7:0] GS8 = 8'(GROUP_SIZE);

  logic          mode;
  logic [CW-1:0] group_position;
  logic [7:0]    group_buffer [GROUP_SIZE];
  logic          final_group_seen;
  status_t       error_code;
  logic          previous_was_ff;

  logic          acc;
  // encode
  logic [CW-1:0] ep, ep1, epn;
  logic          emark;
  // decode
  logic [CW-1:0] dpos_next;
  logic          dfin_next;
  status_t       derr_next;
  logic          dpff_next;
  logic [7:0]    pad8;
  logic          oor;
  logic [CW-1:0] dcount, emit_count;
  logic          padnz;
  logic          buf_we;
  status_t       dstatus;

  assign key_in.ready = push_ready;
  assign acc = key_in.valid && key_in.ready;

  // Encode classification
  always_comb begin
    ep    = (group_position >= GS_C) ? '0 : group_position;
    ep1   = ep + CW'(1);
    emark = key_in.has_byte && (ep1 == GS_C);
    if (key_in.has_byte) begin
      epn = emark ? '0 : ep1;
    end else begin
      epn = ep;
    end
  end

  // Decode classification
  always_comb begin
    dpos_next  = group_position;
    dfin_next  = final_group_seen;
    derr_next  = error_code;
    dpff_next  = previous_was_ff;
    emit_count = '0;
    buf_we     = 1'b0;
    pad8       = MARKER - key_in.in_byte;
    oor        = pad8 > GS8;
    dcount     = CW'(GS8 - pad8);
    padnz      = 1'b0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (CW'(i) >= dcount && group_buffer[i] != ZERO_BYTE) padnz = 1'b1;
    end
    if (key_in.has_byte) begin
      dpff_next = (key_in.in_byte == MARKER);
      if (group_position < GS_C) begin
        buf_we    = !final_group_seen;
        dpos_next = group_position + CW'(1);
      end else begin
        dpos_next = '0;
        if (!final_group_seen) begin
          if (oor) begin
            if (error_code == ST_OK) derr_next = ST_RANGE;
            dfin_next = 1'b1;
          end else begin
            emit_count = dcount;
            if (padnz && error_code == ST_OK) derr_next = ST_PAD;
            if (pad8 != ZERO_BYTE) dfin_next = 1'b1;
          end
        end
      end
    end
    if (dpos_next != '0) begin
      dstatus = ST_LEN;
    end else if (dpff_next) begin
      dstatus = ST_FF;
    end else if (!dfin_next) begin
      dstatus = ST_LEN;
    end else begin
      dstatus = derr_next;
    end
  end

  // Job out
  always_comb begin
    push_ctrl.dec       = mode;
    push_ctrl.data_byte = key_in.in_byte;
    push_ctrl.has       = key_in.has_byte;
    push_ctrl.mark      = emark;
    push_ctrl.key_end   = key_in.key_end;
    push_ctrl.pad       = CNT_W'(GS_C - epn);
    push_ctrl.count     = CNT_W'(emit_count);
    push_ctrl.status    = (mode && key_in.key_end) ? dstatus : ST_OK;
    for (int i = 0; i < GROUP_SIZE; i++) push_data[i] = group_buffer[i];
    if (mode) begin
      push_valid = acc && ((emit_count != '0) || key_in.key_end);
    end else begin
      push_valid = acc && (key_in.has_byte || key_in.key_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= 1'b0;
      group_position   <= '0;
      final_group_seen <= 1'b0;
      error_code       <= ST_OK;
      previous_was_ff  <= 1'b0;
    end else if (cfg_we) begin
      mode             <= cfg_wdata;
      group_position   <= '0;
      final_group_seen <= 1'b0;
      error_code       <= ST_OK;
      previous_was_ff  <= 1'b0;
    end else if (acc) begin
      if (key_in.key_end) begin
        group_position   <= '0;
        final_group_seen <= 1'b0;
        error_code       <= ST_OK;
        previous_was_ff  <= 1'b0;
      end else if (mode) begin
        group_position   <= dpos_next;
        final_group_seen <= dfin_next;
        error_code       <= derr_next;
        previous_was_ff  <= dpff_next;
      end else begin
        group_position   <= epn;
      end
    end
  end

  // Group buffer: payload only, no reset
  always_ff @(posedge clk) begin
    if (acc && mode && buf_we) begin
      group_buffer[group_position[IW-1:0]] <= key_in.in_byte;
    end
  end

endmodule

>>> rtl/core/mkgc_queue.sv
// Two-entry job queue between front and back.
module mkgc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry0, entry1;
  logic [1:0]   cnt;
  logic         push, pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_data   = entry0;
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) entry0 <= push_data;
        else entry1 <= push_data;
      end
      2'b01: begin
        entry0 <= entry1;
      end
      2'b11: begin
        // push allowed only below full, so one entry is held here
        entry0 <= push_data;
      end
      default: begin
        entry0 <= entry0;
      end
    endcase
  end

endmodule

>>> rtl/core/mkgc_back.sv
// Back end: expands the job at the queue head into result transfers, one a cycle while key_out is ready.
`include "memcomparable_key_group_codec_defines.svh"
module mkgc_back
  import mkgc_pkg::*;
#(
  parameter int GROUP_SIZE = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_pop,
  input  job_ctrl_t                  job_ctrl,
  input  logic [GROUP_SIZE-1:0][7:0] job_data,
  mkgc_out_if.source                 key_out
);

  localparam int IW = $clog2(GROUP_SIZE);

  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] off1, off2, off3, total;
  logic             last, xfer;

  always_comb begin
    off1 = CNT_W'(job_ctrl.has);
    off2 = off1 + CNT_W'(job_ctrl.mark);
    off3 = off2 + job_ctrl.pad;
    if (job_ctrl.dec) begin
      total = (job_ctrl.count == '0) ? CNT_W'(1) : job_ctrl.count;
    end else begin
      total = job_ctrl.key_end ? off3 + CNT_W'(1) : off2;
    end
    last = (k == total - CNT_W'(1));
  end

  always_comb begin
    key_out.valid      = job_valid;
    key_out.byte_valid = 1'b1;
    if (job_ctrl.dec) begin
      if (job_ctrl.count == '0) begin
        key_out.out_byte   = ZERO_BYTE;
        key_out.byte_valid = 1'b0;
      end else begin
        key_out.out_byte = job_data[k[IW-1:0]];
      end
    end else if (k < off1) begin
      key_out.out_byte = job_ctrl.data_byte;
    end else if (k < off2) begin
      key_out.out_byte = MARKER;
    end else if (k < off3) begin
      key_out.out_byte = ZERO_BYTE;
    end else begin
      key_out.out_byte = MARKER - 8'(job_ctrl.pad);
    end
    key_out.run_last = last;
    key_out.key_done = last && job_ctrl.key_end;
    key_out.status   = (last && job_ctrl.key_end) ? job_ctrl.status : ST_OK;
  end

  assign xfer    = key_out.valid && key_out.ready;
  assign job_pop = xfer && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (xfer) begin
      k <= last ? '0 : k + CNT_W'(1);
    end
  end

  `MKGC_ASSERT(a_step_holds, clk, rst, key_out.valid && !key_out.ready |=> $stable(k), "step moved while stalled")
  `MKGC_ASSERT(a_step_adv, clk, rst, xfer && !last |=> k == $past(k) + CNT_W'(1), "step did not advance")
  `MKGC_ASSERT(a_status_done, clk, rst, key_out.valid && !key_out.key_done |-> key_out.status == ST_OK, "status without key_done")
  `MKGC_ASSERT(a_done_last, clk, rst, key_out.valid && key_out.key_done |-> key_out.run_last, "key_done off the last result")

endmodule
